// ----- rtl/stamped_hash_cache_top_assert.svh -----
// ----------------------------------------------------------------------------
// Stamped hash cache assertion macros
// Shorthand for the clocked checks used inside the cache RTL.
// ----------------------------------------------------------------------------
`ifndef STAMPED_HASH_CACHE_TOP_ASSERT_SVH
`define STAMPED_HASH_CACHE_TOP_ASSERT_SVH

// check a consequent in the same cycle as its antecedent
`define SHC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stamped hash cache check failed");

// check a consequent in the cycle after its antecedent
`define SHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stamped hash cache check failed");

`endif

// ----- rtl/shc_pkg.sv -----
// ----------------------------------------------------------------------------
// Stamped hash cache package
// Table geometry, hash constants and shared types of the coordinate cache.
// ----------------------------------------------------------------------------
`default_nettype none

package shc_pkg;

   // table geometry
   localparam int TABLE_SLOTS = 256;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int STAMP_BITS  = 16;
   localparam int DATA_BITS   = 8;
   localparam int KEY_BITS    = 64;

   // Fibonacci hash: only product bits up to the top slot bit matter
   localparam logic [KEY_BITS-1:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;
   localparam int HASH_SHIFT = 32;
   localparam int PROD_W     = HASH_SHIFT + SLOT_W;
   localparam int CHUNK_W    = (PROD_W + 1) / 2;
   localparam logic [PROD_W-1:0] MUL_LOW = GOLDEN_MUL[PROD_W-1:0];

   // action codes
   localparam logic ACT_LOOKUP  = 1'b0;
   localparam logic ACT_NEW_GEN = 1'b1;

   // one table entry as stored in the RAM
   typedef struct packed {
      logic [STAMP_BITS-1:0] stamp;
      logic [KEY_BITS-1:0]   key;
      logic [DATA_BITS-1:0]  data;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // sequencer controls for the shared multiplier
   typedef struct packed {
      logic mul_lo;
      logic mul_hi;
   } hash_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/shc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module shc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/shc_hash.sv -----
// ----------------------------------------------------------------------------
// Stamped hash cache hash unit
// Two-step Fibonacci multiply on one shared multiplier; yields the start slot.
// ----------------------------------------------------------------------------
`default_nettype none

module shc_hash (
   input  wire logic                        clock,
   input  wire shc_pkg::hash_ctl_type       ctl,
   input  wire logic [shc_pkg::PROD_W-1:0]  key_low,
   output logic      [shc_pkg::SLOT_W-1:0]  slot
);

   import shc_pkg::*;

   logic [CHUNK_W-1:0]        chunk;
   logic [CHUNK_W+PROD_W-1:0] product;
   logic [PROD_W-1:0]         acc_ff;
   logic [PROD_W-1:0]         acc_in;

   // pick the key chunk for this step
   always_comb begin
      if (ctl.mul_hi) begin
         chunk = CHUNK_W'(key_low[PROD_W-1:CHUNK_W]);
      end else begin
         chunk = key_low[CHUNK_W-1:0];
      end
   end

   // shared multiplier
   assign product = {{PROD_W{1'b0}}, chunk} * {{CHUNK_W{1'b0}}, MUL_LOW};

   // accumulate partial products modulo 2^PROD_W
   always_comb begin
      acc_in = acc_ff;
      if (ctl.mul_lo) begin
         acc_in = product[PROD_W-1:0];
      end else if (ctl.mul_hi) begin
         acc_in = acc_ff + (product[PROD_W-1:0] << CHUNK_W);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign slot = acc_ff[PROD_W-1:HASH_SHIFT];

endmodule

`default_nettype wire

// ----- rtl/stamped_hash_cache_top.sv -----
// ----------------------------------------------------------------------------
// Stamped hash cache top level
// Generation-stamped coordinate cache with hashed, linearly probed table.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive start with the req_ fields; the command transfers
//   at a rising edge with start high and busy low. The result shows on the
//   rsp_ ports for exactly one cycle, marked by rsp_valid; the receiver
//   cannot stall it and must take it in that cycle.
//   New generation: result in the cycle after the transfer, busy stays low.
//   Lookup: busy while ST_HASH_LO and ST_HASH_HI hash the key on one shared
//   multiplier, ST_SEED seeds the probe pointer, and k probes run (k = slots
//   probed, 1 to 256), each one RAM read and one compare. The result strobes
//   in the cycle busy falls, so a new command may transfer then.
//   The table lives in one RAM with registered read; a per-slot valid flag
//   marks stamps that are current since reset or the last generation wrap.
//   Reset: generation 0, all valid flags clear, no clearing pass is needed.
//   Issue a new generation before the first lookup.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stamped_hash_cache_top_assert.svh"

module stamped_hash_cache_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_action,
   input  wire logic signed [25:0]     req_pos_x,
   input  wire logic signed [11:0]     req_pos_y,
   input  wire logic signed [25:0]     req_pos_z,
   input  wire logic [7:0]             req_fill_data,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [7:0]                  rsp_entry_data,
   output logic [7:0]                  rsp_slot_used
);

   import shc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_HASH_LO = 6'b000010,
      ST_HASH_HI = 6'b000100,
      ST_SEED    = 6'b001000,
      ST_READ    = 6'b010000,
      ST_CHECK   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [STAMP_BITS-1:0] gen_ff, gen_in, gen_next;
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [DATA_BITS-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOT_W-1:0]     probe_ff, probe_in;
   logic                  valid_rd_ff, valid_rd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic [7:0]            rsp_slot_ff, rsp_slot_in;

   logic                  accept;
   hash_ctl_type          hash_ctl;
   logic [SLOT_W-1:0]     hash_slot;
   logic                  ram_we;
   logic                  ram_re;
   logic [SLOT_W-1:0]     claim_slot;
   entry_type             wr_entry;
   logic [ENTRY_W-1:0]    rd_bits;
   entry_type             rd_entry;
   logic [STAMP_BITS-1:0] rd_stamp;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // shared hash multiplier
   shc_hash u_hash (
      .clock   (clock),
      .ctl     (hash_ctl),
      .key_low (key_ff[PROD_W-1:0]),
      .slot    (hash_slot)
   );

   // slot table: stamp, key and data per slot
   assign wr_entry.stamp = gen_ff;
   assign wr_entry.key   = key_ff;
   assign wr_entry.data  = fill_ff;

   shc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (claim_slot),
      .wr_data (wr_entry),
      .rd_en   (ram_re),
      .rd_addr (slot_ff),
      .rd_data (rd_bits)
   );

   assign rd_entry = rd_bits;
   // an entry without its valid flag reads as stamp zero
   assign rd_stamp = valid_rd_ff ? rd_entry.stamp : '0;
   assign gen_next = gen_ff + STAMP_BITS'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      valid_in     = valid_ff;
      key_in       = key_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      valid_rd_in  = valid_rd_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_slot_in  = rsp_slot_ff;
      hash_ctl     = '0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      claim_slot   = slot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACT_NEW_GEN) begin
                  // advance the generation; on wrap drop all stamps
                  if (gen_next == '0) begin
                     gen_in   = STAMP_BITS'(1);
                     valid_in = '0;
                  end else begin
                     gen_in = gen_next;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_data_in  = '0;
                  rsp_slot_in  = '0;
               end else begin
                  key_in   = {req_pos_x, req_pos_z, req_pos_y};
                  fill_in  = req_fill_data;
                  state_in = ST_HASH_LO;
               end
            end
         end
         ST_HASH_LO: begin
            hash_ctl.mul_lo = 1'b1;
            state_in        = ST_HASH_HI;
         end
         ST_HASH_HI: begin
            hash_ctl.mul_hi = 1'b1;
            state_in        = ST_SEED;
         end
         ST_SEED: begin
            slot_in  = hash_slot;
            probe_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_re      = 1'b1;
            valid_rd_in = valid_ff[slot_ff];
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_stamp != gen_ff) begin
               // stale slot: claim it
               ram_we               = 1'b1;
               claim_slot           = slot_ff;
               valid_in[claim_slot] = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_hit_in           = 1'b0;
               rsp_data_in          = 8'(fill_ff);
               rsp_slot_in          = 8'(claim_slot);
               state_in             = ST_IDLE;
            end else if (rd_entry.key == key_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_data_in  = 8'(rd_entry.data);
               rsp_slot_in  = 8'(slot_ff);
               state_in     = ST_IDLE;
            end else if (probe_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
               // table full: overwrite the start slot
               ram_we               = 1'b1;
               claim_slot           = slot_ff + SLOT_W'(1);
               valid_in[claim_slot] = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_hit_in           = 1'b0;
               rsp_data_in          = 8'(fill_ff);
               rsp_slot_in          = 8'(claim_slot);
               state_in             = ST_IDLE;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
               probe_in = probe_ff + SLOT_W'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      fill_ff     <= fill_in;
      slot_ff     <= slot_in;
      probe_ff    <= probe_in;
      valid_rd_ff <= valid_rd_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_entry_data = rsp_data_ff;
   assign rsp_slot_used  = rsp_slot_ff;

   // checks
   `SHC_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `SHC_ASSERT_SAME(a_rsp_source, clock, reset, rsp_valid_ff, $past(state_ff == ST_CHECK || accept))
   `SHC_ASSERT_NEXT(a_gen_nonzero, clock, reset, accept && req_action, gen_ff != '0)
   `SHC_ASSERT_NEXT(a_wrap_clears, clock, reset, accept && req_action && gen_ff == '1, valid_ff == '0)
   `SHC_ASSERT_NEXT(a_lookup_hashes, clock, reset, accept && !req_action, state_ff == ST_HASH_LO)

endmodule

`default_nettype wire
